// ----- hw/rtl/mrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mrc_pkg;

   // Page geometry
   localparam int PageBytes = 4096;
   localparam int PageShift = $clog2(PageBytes);

   // Piece list and result limits
   localparam int MaxPieces = 4;
   localparam int MaxOut    = 3;
   localparam int PieceIdxW = $clog2(MaxPieces);
   localparam int PieceCntW = $clog2(MaxPieces + 1);
   localparam int OutCntW   = $clog2(MaxOut);

   // Field widths
   localparam int AddrW  = 32;
   localparam int EndW   = AddrW + 1;
   localparam int CountW = 21;

   // Entry classification
   localparam logic [31:0]     TypeAvailable = 32'd1;
   localparam logic [EndW-1:0] AddrTop       = 33'h1_0000_0000;
   localparam logic [31:0]     LowExcludeLen = 32'h0010_0000;

   // Queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Register indexes
   localparam int CsrIndexW = 2;
   localparam logic [CsrIndexW-1:0] CsrFirstBase  = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrFirstLen   = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrSecondBase = 2'd2;
   localparam logic [CsrIndexW-1:0] CsrSecondLen  = 2'd3;

   typedef struct packed {
      logic [63:0] entry_base;
      logic [63:0] entry_len;
      logic [31:0] entry_type;
   } req_word_type;

   typedef struct packed {
      logic [AddrW-1:0]  page_base;
      logic [CountW-1:0] page_total;
      logic              clipped;
      logic              last;
   } rsp_word_type;

   typedef struct packed {
      logic [AddrW-1:0] first_base;
      logic [AddrW-1:0] first_len;
      logic [AddrW-1:0] second_base;
      logic [AddrW-1:0] second_len;
   } excl_type;

   typedef struct packed {
      logic [EndW-1:0] pb;
      logic [EndW-1:0] pe;
   } piece_type;

   typedef struct packed {
      piece_type [MaxPieces-1:0] p;
      logic [PieceCntW-1:0]      count;
      logic                      clip;
   } plist_type;

   // One carved entry: per-slot keep flag, aligned base and page count
   typedef struct packed {
      logic                               clip;
      logic [MaxPieces-1:0]               keep;
      logic [MaxPieces-1:0][AddrW-1:0]    base;
      logic [MaxPieces-1:0][CountW-1:0]   pages;
   } carve_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mrc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrc_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  mrc_pkg::req_word_type req_word,
   input  mrc_pkg::excl_type     excl,
   input  wire                   queue_full,
   output logic                  push,
   output mrc_pkg::carve_type    push_data
);

   // Cut one exclusion range out of every live piece, appending split tails
   function automatic mrc_pkg::plist_type cut_pieces(
      input mrc_pkg::plist_type lst,
      input logic [mrc_pkg::AddrW-1:0] xs,
      input logic [mrc_pkg::AddrW-1:0] xlen);
      mrc_pkg::plist_type res;
      logic [mrc_pkg::EndW-1:0] xsum;
      logic [mrc_pkg::EndW-1:0] xe;
      logic [mrc_pkg::EndW-1:0] xs_w;
      logic [mrc_pkg::EndW-1:0] s;
      logic [mrc_pkg::EndW-1:0] e;
      logic hb;
      logic ha;
      begin
         xs_w = {1'b0, xs};
         xsum = {1'b0, xs} + {1'b0, xlen};
         xe   = (xsum > mrc_pkg::AddrTop) ? mrc_pkg::AddrTop : xsum;
         res  = lst;
         for (int j = 0; j < mrc_pkg::MaxPieces; j++) begin
            s = lst.p[j].pb;
            e = lst.p[j].pe;
            if ((mrc_pkg::PieceCntW'(j) < lst.count) && (e > s) &&
                !((e <= xs_w) || (xe <= s))) begin
               hb = s < xs_w;
               ha = xe < e;
               if (hb && ha) begin
                  res.p[j].pe = xs_w;
                  if (res.count < mrc_pkg::PieceCntW'(mrc_pkg::MaxPieces)) begin
                     res.p[res.count[mrc_pkg::PieceIdxW-1:0]].pb = xe;
                     res.p[res.count[mrc_pkg::PieceIdxW-1:0]].pe = e;
                     res.count = res.count + mrc_pkg::PieceCntW'(1);
                  end
               end else if (hb) begin
                  res.p[j].pe = xs_w;
               end else if (ha) begin
                  res.p[j].pb = xe;
               end else begin
                  res.p[j].pe = s;
               end
            end
         end
         return res;
      end
   endfunction

   // Round each piece up to a page and count its whole pages
   function automatic mrc_pkg::carve_type align_pieces(input mrc_pkg::plist_type lst);
      mrc_pkg::carve_type res;
      logic [mrc_pkg::EndW-1:0] s;
      logic [mrc_pkg::EndW-1:0] e;
      logic [mrc_pkg::EndW-1:0] aup;
      logic [mrc_pkg::EndW-1:0] pg;
      begin
         res.clip = lst.clip;
         for (int j = 0; j < mrc_pkg::MaxPieces; j++) begin
            s   = lst.p[j].pb;
            e   = lst.p[j].pe;
            aup = (s + mrc_pkg::EndW'(mrc_pkg::PageBytes - 1)) &
                  ~mrc_pkg::EndW'(mrc_pkg::PageBytes - 1);
            pg  = (e - aup) >> mrc_pkg::PageShift;
            res.keep[j] = (mrc_pkg::PieceCntW'(j) < lst.count) && (e > s) &&
                          (aup < e) && (pg != '0);
            res.base[j] = aup[mrc_pkg::AddrW-1:0];
            res.pages[j] = (|pg[mrc_pkg::EndW-1:mrc_pkg::CountW]) ?
                           {mrc_pkg::CountW{1'b1}} : pg[mrc_pkg::CountW-1:0];
         end
         return res;
      end
   endfunction

   logic               s1_vld_ff, s1_vld_in;
   logic               s2_vld_ff, s2_vld_in;
   logic               s3_vld_ff, s3_vld_in;
   mrc_pkg::plist_type s1_ff, s1_in;
   mrc_pkg::plist_type s2_ff, s2_in;
   mrc_pkg::plist_type s3_ff, s3_in;

   logic                       advance;
   logic                       pass;
   logic                       over;
   logic [mrc_pkg::EndW-1:0]   base_w;
   logic [mrc_pkg::EndW-1:0]   room;
   logic [mrc_pkg::EndW-1:0]   end_w;
   mrc_pkg::carve_type         carve;

   // Advance the whole front unless the last stage waits on a full queue
   assign advance   = !s3_vld_ff || !queue_full;
   assign req_stall = !advance;

   // Classify the entry and clip its end at the top of the 32-bit space
   always_comb begin
      pass   = (req_word.entry_type == mrc_pkg::TypeAvailable) &&
               (req_word.entry_base[63:32] == 32'd0) &&
               (req_word.entry_len != 64'd0);
      base_w = {1'b0, req_word.entry_base[31:0]};
      room   = mrc_pkg::AddrTop - base_w;
      over   = (req_word.entry_len[63:33] != '0) ||
               (req_word.entry_len[32:0] > room);
      end_w  = over ? mrc_pkg::AddrTop : (base_w + req_word.entry_len[32:0]);
      s1_in          = '0;
      s1_in.p[0].pb  = base_w;
      s1_in.p[0].pe  = end_w;
      s1_in.count    = mrc_pkg::PieceCntW'(1);
      s1_in.clip     = over;
   end

   // Cut the two exclusion ranges in order
   always_comb begin
      s1_vld_in = req_valid && pass;
      s2_vld_in = s1_vld_ff;
      s3_vld_in = s2_vld_ff;
      s2_in     = cut_pieces(s1_ff, excl.first_base, excl.first_len);
      s3_in     = cut_pieces(s2_ff, excl.second_base, excl.second_len);
   end

   // Hand entries with at least one usable piece to the queue
   assign carve     = align_pieces(s3_ff);
   assign push      = s3_vld_ff && !queue_full && (|carve.keep);
   assign push_data = carve;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mrc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrc_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  mrc_pkg::carve_type push_data,
   output logic               full,
   input  wire                pop,
   output logic               nonempty,
   output mrc_pkg::carve_type pop_data
);

   mrc_pkg::carve_type                slot_ff [mrc_pkg::QueueDepth];
   logic [mrc_pkg::QueuePtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mrc_pkg::QueuePtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mrc_pkg::QueueCntW-1:0]     fill_ff, fill_in;

   assign full     = (fill_ff == mrc_pkg::QueueCntW'(mrc_pkg::QueueDepth));
   assign nonempty = (fill_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Wrap pointers and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mrc_pkg::QueuePtrW'(mrc_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + mrc_pkg::QueuePtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mrc_pkg::QueuePtrW'(mrc_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + mrc_pkg::QueuePtrW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + mrc_pkg::QueueCntW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - mrc_pkg::QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mrc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrc_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   queue_nonempty,
   input  mrc_pkg::carve_type    queue_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output mrc_pkg::rsp_word_type rsp_word
);

   logic                        cur_vld_ff, cur_vld_in;
   mrc_pkg::carve_type          cur_ff, cur_in;
   logic [mrc_pkg::OutCntW-1:0] num_ff, num_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   mrc_pkg::rsp_word_type       rsp_word_ff, rsp_word_in;

   logic                           out_load;
   logic                           emit;
   logic                           is_last;
   logic                           found;
   logic [mrc_pkg::MaxPieces-1:0]  pick;
   logic [mrc_pkg::MaxPieces-1:0]  rest;
   logic [mrc_pkg::AddrW-1:0]      sel_base;
   logic [mrc_pkg::CountW-1:0]     sel_pages;

   // Pick the lowest-indexed remaining piece of the current entry
   always_comb begin
      found     = 1'b0;
      pick      = '0;
      sel_base  = '0;
      sel_pages = '0;
      for (int j = 0; j < mrc_pkg::MaxPieces; j++) begin
         pick[j] = cur_ff.keep[j] && !found;
         found   = found || cur_ff.keep[j];
         if (pick[j]) begin
            sel_base  = cur_ff.base[j];
            sel_pages = cur_ff.pages[j];
         end
      end
      rest    = cur_ff.keep & ~pick;
      is_last = (rest == '0) || (num_ff == mrc_pkg::OutCntW'(mrc_pkg::MaxOut - 1));
   end

   // Emit one piece per cycle while the output is not stalled; fetch the next entry as the last piece leaves
   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign emit     = cur_vld_ff && out_load;
   assign pop      = queue_nonempty && (!cur_vld_ff || (emit && is_last));

   always_comb begin
      cur_vld_in   = cur_vld_ff;
      cur_in       = cur_ff;
      num_in       = num_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (pop) begin
         cur_vld_in = 1'b1;
         cur_in     = queue_data;
         num_in     = '0;
      end else if (emit) begin
         cur_vld_in  = !is_last;
         cur_in.keep = rest;
         num_in      = num_ff + mrc_pkg::OutCntW'(1);
      end
      if (out_load) begin
         rsp_valid_in           = emit;
         rsp_word_in.page_base  = sel_base;
         rsp_word_in.page_total = sel_pages;
         rsp_word_in.clipped    = cur_ff.clip;
         rsp_word_in.last       = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_vld_ff   <= cur_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      num_ff      <= num_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/memory_range_carver.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// req       in         req_valid/req_stall  entry_base, entry_len, entry_type
// rsp       out        rsp_valid/rsp_stall  page_base, page_total, clipped, last
// csr       in         csr_wr_en            csr_index, csr_wdata (no read-back)
//
// An entry passes the front's classify, first-cut and second-cut stages, then a
// two-entry queue and the back's current-entry and output registers; its one to
// three pieces leave one per cycle while rsp_stall is low.
// The front takes an entry every cycle unless its last stage waits on a full queue.
// Reset is synchronous; exclusions come up as base 0 / 1 MiB and base 0 / 0.
// rsp_stall holds the output word; a full queue stalls req when the front's last stage holds an entry.

module memory_range_carver (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  mrc_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output mrc_pkg::rsp_word_type               rsp_word,
   input  wire                                 csr_wr_en,
   input  wire [mrc_pkg::CsrIndexW-1:0]        csr_index,
   input  wire [mrc_pkg::AddrW-1:0]            csr_wdata
);

   mrc_pkg::excl_type  excl_ff, excl_in;
   mrc_pkg::carve_type push_data;
   mrc_pkg::carve_type queue_data;
   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_nonempty;

   // Update the addressed exclusion register
   always_comb begin
      excl_in = excl_ff;
      if (csr_wr_en) begin
         case (csr_index)
            mrc_pkg::CsrFirstBase:  excl_in.first_base  = csr_wdata;
            mrc_pkg::CsrFirstLen:   excl_in.first_len   = csr_wdata;
            mrc_pkg::CsrSecondBase: excl_in.second_base = csr_wdata;
            mrc_pkg::CsrSecondLen:  excl_in.second_len  = csr_wdata;
            default: excl_in = excl_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         excl_ff.first_base  <= '0;
         excl_ff.first_len   <= mrc_pkg::LowExcludeLen;
         excl_ff.second_base <= '0;
         excl_ff.second_len  <= '0;
      end else begin
         excl_ff <= excl_in;
      end
   end

   mrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .excl       (excl_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   mrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .nonempty  (queue_nonempty),
      .pop_data  (queue_data)
   );

   mrc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_nonempty (queue_nonempty),
      .queue_data     (queue_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/mrc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrc_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input mrc_pkg::rsp_word_type rsp_word
);

   // Output word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // Every piece carries at least one page
   a_nonzero_pages: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.page_total != '0)
      else $error("piece with no pages");

   // Every base is page aligned
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.page_base &
                     mrc_pkg::AddrW'(mrc_pkg::PageBytes - 1)) == '0)
      else $error("unaligned page base");

   // Output drops right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind memory_range_carver mrc_checker u_mrc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire
